// ===== sv/pdc_pkg.sv =====
// Package for the packet deframer: payload types, codes and CRC helper.
package pdc_pkg;

	localparam int HeaderBytes = 12;
	localparam logic [15:0] MaxLengthReset = 16'd512;
	localparam int QueueDepth = 4;
	localparam logic [31:0] CrcPoly = 32'hEDB88320;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_TYPE = 3'd1,
		ST_LENGTH = 3'd2,
		ST_HCRC = 3'd3,
		ST_PCRC = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [1:0]  pkt_type;
		logic        truncated;
		logic [4:0]  window;
		logic [7:0]  seqnum;
		logic [15:0] length;
		logic [31:0] timestamp;
		logic        last;
	} out_item_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CrcPoly & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

// ===== sv/pdc_parser.sv =====
// Front end: accepts bytes, tracks header and CRC state, classifies results.
module pdc_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  pdc_pkg::in_item_t   in_item,
	input  logic                in_fire,
	input  logic [15:0]         max_length,
	output logic                res_valid,
	output pdc_pkg::out_item_t  res_item
);
	typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PAYLOAD, PH_TRAILER} phase_t;

	phase_t      phase_q;
	logic [16:0] pos_q;
	logic [1:0]  type_q;
	logic        trunc_q;
	logic [4:0]  win_q;
	logic [7:0]  seq_q;
	logic [15:0] len_q;
	logic [31:0] ts_q;
	logic [31:0] crc_q;
	logic [31:0] rcrc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		logic [7:0]  b;
		logic [16:0] p;
		logic [16:0] np;
		logic [1:0]  ty;
		logic        tr;
		logic [4:0]  wi;
		logic [7:0]  sq;
		logic [15:0] ln;
		logic [31:0] ts;
		logic [31:0] cr;
		logic [31:0] rc;
		phase_t      ph;
		logic        rv;
		pdc_pkg::out_item_t ri;
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0;
			type_q <= '0;
			trunc_q <= 1'b0;
			win_q <= '0;
			seq_q <= '0;
			len_q <= '0;
			ts_q <= '0;
			crc_q <= '1;
			rcrc_q <= '0;
			res_valid <= 1'b0;
			res_item <= '0;
		end else begin
			rv = 1'b0;
			ri = '0;
			if (in_fire && (in_item.frame_start || phase_q != PH_IDLE)) begin
				b = in_item.data_byte;
				ph = phase_q; p = pos_q; ty = type_q; tr = trunc_q; wi = win_q;
				sq = seq_q; ln = len_q; ts = ts_q; cr = crc_q; rc = rcrc_q;
				if (in_item.frame_start) begin
					ph = PH_HEADER; p = '0; ty = '0; tr = 1'b0; wi = '0;
					sq = '0; ln = '0; ts = '0; cr = '1; rc = '0;
				end
				np = p + 17'd1;
				unique case (ph)
					PH_HEADER: begin
						if (p == 17'd0) begin
							ty = b[7:6]; tr = b[5]; wi = b[4:0];
							cr = pdc_pkg::crc_byte(cr, b & 8'hDF);
						end else if (p == 17'd1) begin
							sq = b;
							cr = pdc_pkg::crc_byte(cr, b);
						end else if (p < 17'd4) begin
							ln = {ln[7:0], b};
							cr = pdc_pkg::crc_byte(cr, b);
						end else if (p < 17'd8) begin
							ts = ts | ({24'd0, b} << (5'd8 * p[1:0]));
							cr = pdc_pkg::crc_byte(cr, b);
						end else begin
							rc = {rc[23:0], b};
						end
					end
					PH_PAYLOAD: begin
						cr = pdc_pkg::crc_byte(cr, b);
						if (np >= 17'(pdc_pkg::HeaderBytes) + {1'b0, ln}) ph = PH_TRAILER;
					end
					default: rc = {rc[23:0], b};
				endcase
				ri.pkt_type = ty; ri.truncated = tr; ri.window = wi;
				ri.seqnum = sq; ri.length = ln; ri.timestamp = ts;
				if (phase_q == PH_HEADER || in_item.frame_start) begin
					if (p == 17'd0 && (ty == 2'd0 || (tr && ty != 2'd1))) begin
						rv = 1'b1; ph = PH_IDLE;
						ri.result_kind = 1'b1; ri.last = 1'b1;
						ri.status = pdc_pkg::ST_TYPE;
					end else if (p == 17'd3 && ln > max_length) begin
						rv = 1'b1; ph = PH_IDLE;
						ri.result_kind = 1'b1; ri.last = 1'b1;
						ri.status = pdc_pkg::ST_LENGTH;
					end else if (p == 17'(pdc_pkg::HeaderBytes - 1)) begin
						if (~cr != rc) begin
							rv = 1'b1; ph = PH_IDLE;
							ri.result_kind = 1'b1; ri.last = 1'b1;
							ri.status = pdc_pkg::ST_HCRC;
						end else if (ln == 16'd0) begin
							rv = 1'b1; ph = PH_IDLE;
							ri.result_kind = 1'b1; ri.last = 1'b1;
							ri.status = pdc_pkg::ST_OK;
						end else begin
							ph = PH_PAYLOAD; cr = '1; rc = '0;
						end
					end
				end else if (phase_q == PH_PAYLOAD) begin
					rv = 1'b1;
					ri.payload_byte = b;
				end else if (np >= 17'(pdc_pkg::HeaderBytes + 4) + {1'b0, ln}) begin
					rv = 1'b1; ph = PH_IDLE;
					ri.result_kind = 1'b1; ri.last = 1'b1;
					ri.status = (~cr != rc) ? pdc_pkg::ST_PCRC : pdc_pkg::ST_OK;
				end
				phase_q <= ph; pos_q <= np; type_q <= ty; trunc_q <= tr; win_q <= wi;
				seq_q <= sq; len_q <= ln; ts_q <= ts; crc_q <= cr; rcrc_q <= rc;
			end
			res_valid <= rv;
			res_item <= ri;
		end
	end
endmodule

// ===== sv/pdc_queue.sv =====
// Back end: result queue between the parser and the output channel.
module pdc_queue #(
	parameter int Depth = pdc_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	input  pdc_pkg::out_item_t wr_item,
	output logic               space_ok,
	output logic               rd_valid,
	input  logic               rd_ready,
	output pdc_pkg::out_item_t rd_item
);
	localparam int AW = $clog2(Depth);
	pdc_pkg::out_item_t mem [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic rd_fire;

	assign rd_valid = cnt_q != '0;
	assign rd_item = mem[rp_q];
	assign rd_fire = rd_valid && rd_ready;
	// room for the item in flight plus one more
	assign space_ok = cnt_q < (AW+1)'(Depth - 1);

	always_ff @(posedge clk) begin
		if (wr_valid) mem[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_valid) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd_fire) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_valid) - (AW+1)'(rd_fire);
		end
	end
endmodule

// ===== sv/packet_deframer_crc32_check_top.sv =====
// Packet deframer with header and payload CRC-32 checks: top level.
// A result is registered in the parser and then written into the queue, which holds it until out_ready takes it.
// Throughput: one byte per cycle while in_ready is high; the byte-wide CRC update sets the figure.
// in_ready drops only while the result queue is nearly full.
// Reset clears parser state and the queue, and sets max_length to 512.
module packet_deframer_crc32_check_top #(
	parameter int QueueDepth = pdc_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pdc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pdc_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);
	logic [15:0] max_len_q;
	logic res_valid;
	pdc_pkg::out_item_t res_item;
	logic in_fire;

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_len_q <= pdc_pkg::MaxLengthReset;
		else if (cfg_we) max_len_q <= cfg_wdata;
	end

	pdc_parser u_parser (
		.clk, .arst_n, .in_item(in_data), .in_fire, .max_length(max_len_q),
		.res_valid, .res_item
	);

	pdc_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .wr_valid(res_valid), .wr_item(res_item), .space_ok(in_ready),
		.rd_valid(out_valid), .rd_ready(out_ready), .rd_item(out_data)
	);

`ifndef SYNTH
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.last == out_data.result_kind) else $error("last mismatch");
	a_pay_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.result_kind |-> out_data.status == pdc_pkg::ST_OK)
		else $error("status on payload");
	a_no_input_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> !res_valid) else $error("result without request");
`endif
endmodule
